FILE: design/etl_pkg.sv
// Package for the expression token lexer: widths, token kind codes,
// character codes and the token record. No dependencies.
`default_nettype none

package etl_pkg;

   localparam int POSITION_BITS = 16;
   localparam int FIELD_BITS    = 16;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // token kinds
   localparam logic [3:0] KIND_NUMBER  = 4'd0;
   localparam logic [3:0] KIND_IDENT   = 4'd1;
   localparam logic [3:0] KIND_EQUALS  = 4'd2;
   localparam logic [3:0] KIND_PLUS    = 4'd3;
   localparam logic [3:0] KIND_MINUS   = 4'd4;
   localparam logic [3:0] KIND_STAR    = 4'd5;
   localparam logic [3:0] KIND_SLASH   = 4'd6;
   localparam logic [3:0] KIND_OPEN    = 4'd7;
   localparam logic [3:0] KIND_CLOSE   = 4'd8;
   localparam logic [3:0] KIND_LET     = 4'd9;
   localparam logic [3:0] KIND_ILLEGAL = 4'd10;
   localparam logic [3:0] KIND_EOF     = 4'd11;

   // open run kinds
   localparam logic [1:0] RUN_NONE = 2'd0;
   localparam logic [1:0] RUN_NUM  = 2'd1;
   localparam logic [1:0] RUN_ID   = 2'd2;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam int LET_LENGTH = 3;

   // result queue
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = 2;
   localparam int FIFO_CNT_BITS  = 3;

   typedef struct packed {
      logic [3:0]            kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic                  last;
   } token_type;

   // what one accepted byte produces: up to two tokens, in order
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } lex_out_type;

   function automatic logic [7:0] let_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = CH_LOW_L;
         2'd1:    ch = CH_LOW_E;
         2'd2:    ch = CH_LOW_T;
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: design/etl_core.sv
// Lexer state and token generation for one byte per transaction.
// Depends on etl_pkg.
`default_nettype none

module etl_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           text_byte,
   output etl_pkg::lex_out_type      lex_out
);
   import etl_pkg::*;

   logic [1:0]               run_kind_ff, run_kind_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;
   logic [POSITION_BITS-1:0] run_length_ff, run_length_in;
   logic                     keyword_match_ff, keyword_match_in;
   logic [POSITION_BITS-1:0] byte_position_ff, byte_position_in;

   logic       is_digit, is_word, is_space, cont, have_run;
   logic       have_single, is_eof;
   logic [3:0] single_kind;
   token_type  run_tok, second_tok;

   always_comb begin
      is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
      is_word  = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                 ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                 (text_byte == CH_UNDER);
      is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                 (text_byte == CH_LF) || (text_byte == CH_CR);
      is_eof   = (text_byte == CH_NUL);
      cont     = ((run_kind_ff == RUN_NUM) && is_digit) ||
                 ((run_kind_ff == RUN_ID) && is_word);
      have_run = (run_kind_ff == RUN_NUM) || (run_kind_ff == RUN_ID);

      unique case (text_byte)
         CH_EQUALS: single_kind = KIND_EQUALS;
         CH_PLUS:   single_kind = KIND_PLUS;
         CH_MINUS:  single_kind = KIND_MINUS;
         CH_STAR:   single_kind = KIND_STAR;
         CH_SLASH:  single_kind = KIND_SLASH;
         CH_OPEN:   single_kind = KIND_OPEN;
         CH_CLOSE:  single_kind = KIND_CLOSE;
         default:   single_kind = KIND_ILLEGAL;
      endcase

      run_tok.kind   = KIND_NUMBER;
      if (run_kind_ff == RUN_ID)
         run_tok.kind = (keyword_match_ff &&
                         run_length_ff == POSITION_BITS'(LET_LENGTH)) ? KIND_LET : KIND_IDENT;
      run_tok.start  = FIELD_BITS'(run_start_ff);
      run_tok.length = FIELD_BITS'(run_length_ff);
      run_tok.last   = 1'b0;

      have_single       = is_eof || !(is_space || is_digit || is_word);
      second_tok.kind   = is_eof ? KIND_EOF : single_kind;
      second_tok.start  = FIELD_BITS'(byte_position_ff);
      second_tok.length = is_eof ? '0 : FIELD_BITS'(1);
      second_tok.last   = 1'b1;

      run_kind_in      = run_kind_ff;
      run_start_in     = run_start_ff;
      run_length_in    = run_length_ff;
      keyword_match_in = keyword_match_ff;
      byte_position_in = (byte_position_ff != POS_MAX) ? byte_position_ff + 1'b1
                                                       : byte_position_ff;
      lex_out.count  = 2'd0;
      lex_out.first  = second_tok;
      lex_out.second = second_tok;

      if (cont) begin
         if (keyword_match_ff)
            keyword_match_in = (run_length_ff < POSITION_BITS'(LET_LENGTH)) &&
                               (text_byte == let_char(run_length_ff[1:0]));
         if (run_length_ff != POS_MAX)
            run_length_in = run_length_ff + 1'b1;
      end else begin
         // close the open run (if any), then treat the byte on its own
         run_kind_in      = RUN_NONE;
         run_start_in     = '0;
         run_length_in    = '0;
         keyword_match_in = 1'b1;
         if (is_eof) begin
            byte_position_in = '0;
         end else if (is_digit || is_word) begin
            run_kind_in      = is_digit ? RUN_NUM : RUN_ID;
            run_start_in     = byte_position_ff;
            run_length_in    = POSITION_BITS'(1);
            keyword_match_in = is_word && (text_byte == CH_LOW_L);
         end
         if (have_run) begin
            lex_out.first       = run_tok;
            lex_out.first.last  = !have_single;
            lex_out.count       = have_single ? 2'd2 : 2'd1;
         end else begin
            lex_out.count       = have_single ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff      <= RUN_NONE;
         run_start_ff     <= '0;
         run_length_ff    <= '0;
         keyword_match_ff <= 1'b1;
         byte_position_ff <= '0;
      end else if (accept) begin
         run_kind_ff      <= run_kind_in;
         run_start_ff     <= run_start_in;
         run_length_ff    <= run_length_in;
         keyword_match_ff <= keyword_match_in;
         byte_position_ff <= byte_position_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/etl_fifo.sv
// Four-entry token queue taking up to two tokens per cycle, giving one.
// Depends on etl_pkg.
`default_nettype none

module etl_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire etl_pkg::lex_out_type push,
   input  wire logic                 push_en,
   output logic                      has_room,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output etl_pkg::token_type        out_token
);
   import etl_pkg::*;

   token_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]               push_n;
   logic                     pop;

   always_comb begin
      out_valid = (count_ff != '0);
      out_token = entry_ff[rptr_ff];
      push_n    = push_en ? push.count : 2'd0;
      pop       = out_valid && out_ready;
      wptr_in   = wptr_ff + FIFO_PTR_BITS'(push_n);
      rptr_in   = rptr_ff + FIFO_PTR_BITS'(pop);
      count_in  = count_ff + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
      // room for the worst case of two tokens from one byte
      has_room  = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0)
         entry_ff[wptr_ff] <= push.first;
      if (push_n == 2'd2)
         entry_ff[wptr_ff + 1'b1] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/expression_token_lexer_unit.sv
// Top level of the expression token lexer: lexer core plus token queue.
// Depends on etl_pkg, etl_core, etl_fifo.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  text_byte (8)
//   rsp_     out        rsp_valid/rsp_ready  token_kind, token_start, token_length, last_result
//
// One byte is taken per cycle while the queue has room for two tokens; the tokens
// are registered in the queue and leave from its head in order. A byte that closes a
// run and also gives a token of its own produces two tokens, which the one-token
// output drains one at a time; the four-entry queue absorbs this.
// Synchronous reset clears the run state, position and queue.
// Back-pressure on rsp_ drops req_ready once fewer than two queue entries are free.
`default_nettype none

module expression_token_lexer_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_text_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [3:0]                 rsp_token_kind,
   output logic [15:0]                rsp_token_start,
   output logic [15:0]                rsp_token_length,
   output logic                       rsp_last_result
);
   import etl_pkg::*;

   lex_out_type lex_out;
   token_type   head;
   logic        accept;

   assign accept = req_valid && req_ready;

   etl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .lex_out   (lex_out)
   );

   etl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (lex_out),
      .push_en   (accept),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_token (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last_result  = head.last;

endmodule

`default_nettype wire

FILE: design/etl_checker.sv
// Port-level checks for the expression token lexer, bound to the top level.
// Depends on etl_pkg and expression_token_lexer_unit.
`default_nettype none

module etl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_text_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_token_kind,
   input wire logic [15:0] rsp_token_start,
   input wire logic [15:0] rsp_token_length,
   input wire logic        rsp_last_result
);
   import etl_pkg::*;

   // a stalled token stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_token_start) && $stable(rsp_token_length))
      else $error("rsp token changed while stalled");

   // end of text is always the final token of its byte, and empty
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_EOF |-> rsp_last_result && rsp_token_length == '0)
      else $error("eof token malformed");

   // operator and bracket tokens are one character and end their byte's tokens
   a_single_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind >= KIND_EQUALS && rsp_token_kind <= KIND_CLOSE
      |-> rsp_token_length == 16'd1 && rsp_last_result)
      else $error("single-character token malformed");

   // an accepted end-of-text byte leaves a token ready next cycle
   a_eof_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_text_byte == CH_NUL |=> rsp_valid)
      else $error("no token after end of text");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= KIND_EOF && rsp_token_length != '0 ||
      rsp_token_kind == KIND_EOF)
      else $error("bad token kind or empty token");

endmodule

bind expression_token_lexer_unit etl_checker u_etl_checker (.*);

`default_nettype wire

FILE: tb/sv/etl_token_checker.sv
// Token checker for the expression token lexer: watches both channels, works
// out the tokens each accepted byte must give and compares them in order.
// Depends on etl_pkg.
module etl_token_checker
   import etl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [3:0]  rsp_token_kind,
   input  wire logic [15:0] rsp_token_start,
   input  wire logic [15:0] rsp_token_length,
   input  wire logic        rsp_last_result,
   output int               failures,
   output int               tokens_outstanding,
   output int               bytes_lexed,
   output int               tokens_checked,
   output logic [11:0]      kinds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 25;

   // lexer state as the block should hold it
   logic [1:0]               run_kind;
   logic [POSITION_BITS-1:0] run_start;
   logic [POSITION_BITS-1:0] run_length;
   logic                     keyword_prefix;
   logic [POSITION_BITS-1:0] text_position;

   token_type tokens_due[$];

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
   endfunction

   task automatic report_mismatch(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("[%0t] lexer mismatch: %s", $time, msg);
   endtask

   task automatic clear_run();
      run_kind       = RUN_NONE;
      run_start      = '0;
      run_length     = '0;
      keyword_prefix = 1'b1;
   endtask

   task automatic open_run(input logic [1:0] kind, input logic [7:0] c);
      run_kind       = kind;
      run_start      = text_position;
      run_length     = 1;
      keyword_prefix = (kind == RUN_ID) && (c == CH_LOW_L);
   endtask

   // expected tokens for one accepted byte, queued in output order
   task automatic lex_byte(input logic [7:0] c);
      token_type  made[2];
      int         n_made;
      logic       grows;
      logic [3:0] single;
      n_made = 0;
      grows  = (run_kind == RUN_NUM && is_digit(c)) || (run_kind == RUN_ID && is_word(c));
      if (grows) begin
         if (keyword_prefix)
            keyword_prefix = (run_length == 1 && c == CH_LOW_E) ||
                             (run_length == 2 && c == CH_LOW_T);
         if (run_length != POS_MAX)
            run_length++;
      end else begin
         if (run_kind == RUN_NUM || run_kind == RUN_ID) begin
            if (run_kind == RUN_NUM)
               made[n_made].kind = KIND_NUMBER;
            else if (keyword_prefix && run_length == LET_LENGTH)
               made[n_made].kind = KIND_LET;
            else
               made[n_made].kind = KIND_IDENT;
            made[n_made].start  = run_start;
            made[n_made].length = run_length;
            made[n_made].last   = 1'b0;
            n_made++;
         end
         clear_run();
         if (c == CH_NUL) begin
            made[n_made].kind   = KIND_EOF;
            made[n_made].start  = text_position;
            made[n_made].length = '0;
            made[n_made].last   = 1'b0;
            n_made++;
         end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            // skipped
         end else if (is_digit(c)) begin
            open_run(RUN_NUM, c);
         end else if (is_word(c)) begin
            open_run(RUN_ID, c);
         end else begin
            case (c)
               CH_EQUALS: single = KIND_EQUALS;
               CH_PLUS:   single = KIND_PLUS;
               CH_MINUS:  single = KIND_MINUS;
               CH_STAR:   single = KIND_STAR;
               CH_SLASH:  single = KIND_SLASH;
               CH_OPEN:   single = KIND_OPEN;
               CH_CLOSE:  single = KIND_CLOSE;
               default:   single = KIND_ILLEGAL;
            endcase
            made[n_made].kind   = single;
            made[n_made].start  = text_position;
            made[n_made].length = 1;
            made[n_made].last   = 1'b0;
            n_made++;
         end
      end
      // end of text restarts the offsets, everything else advances them
      if (!grows && c == CH_NUL)
         text_position = '0;
      else if (text_position != POS_MAX)
         text_position++;
      if (n_made > 0)
         made[n_made-1].last = 1'b1;
      for (int i = 0; i < n_made; i++)
         tokens_due.push_back(made[i]);
   endtask

   task automatic check_token();
      token_type want;
      if (tokens_due.size() == 0) begin
         report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                   rsp_token_kind, rsp_token_start, rsp_token_length));
      end else begin
         want = tokens_due.pop_front();
         if (rsp_token_kind !== want.kind)
            report_mismatch($sformatf("token %0d kind: want %0d got %0d",
                                      tokens_checked, want.kind, rsp_token_kind));
         if (rsp_token_start !== want.start)
            report_mismatch($sformatf("token %0d start: want %0d got %0d",
                                      tokens_checked, want.start, rsp_token_start));
         if (rsp_token_length !== want.length)
            report_mismatch($sformatf("token %0d length: want %0d got %0d",
                                      tokens_checked, want.length, rsp_token_length));
         if (rsp_last_result !== want.last)
            report_mismatch($sformatf("token %0d last flag: want %0b got %0b",
                                      tokens_checked, want.last, rsp_last_result));
         kinds_seen[want.kind] = 1'b1;
         tokens_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_run();
         text_position = '0;
         tokens_due.delete();
         kinds_seen = '0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_token();
         if (req_valid && req_ready) begin
            lex_byte(req_text_byte);
            bytes_lexed++;
         end
      end
      tokens_outstanding = tokens_due.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for expression_token_lexer_unit: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on etl_pkg, the lexer RTL and
// etl_token_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import etl_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 1900;
   localparam int HOLD_CYCLES    = 64;
   localparam int DRAIN_CYCLES   = 16;
   localparam int TIMEOUT_CYCLES = 500_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_last_result;

   int          failures;
   int          tokens_outstanding;
   int          bytes_lexed;
   int          tokens_checked;
   logic [11:0] kinds_seen;

   logic [7:0]  text_buf[$];
   int          sender_mode = 0;
   int          burst_left = 0;
   int          items_sent = 0;
   int          hold_requests = 0;
   int          holds_served = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   expression_token_lexer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_result  (rsp_last_result)
   );

   etl_token_checker lex_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_token_start    (rsp_token_start),
      .rsp_token_length   (rsp_token_length),
      .rsp_last_result    (rsp_last_result),
      .failures           (failures),
      .tokens_outstanding (tokens_outstanding),
      .bytes_lexed        (bytes_lexed),
      .tokens_checked     (tokens_checked),
      .kinds_seen         (kinds_seen)
   );

   // ---------------- text generation ----------------

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
   endtask

   task automatic push_blank();
      case ($urandom_range(0, 3))
         0:       text_buf.push_back(CH_SPACE);
         1:       text_buf.push_back(CH_TAB);
         2:       text_buf.push_back(CH_LF);
         default: text_buf.push_back(CH_CR);
      endcase
   endtask

   task automatic gen_ws(input int min_count);
      repeat ($urandom_range(min_count, 2)) push_blank();
   endtask

   task automatic push_symbol();
      case ($urandom_range(0, 6))
         0:       text_buf.push_back(CH_EQUALS);
         1:       text_buf.push_back(CH_PLUS);
         2:       text_buf.push_back(CH_MINUS);
         3:       text_buf.push_back(CH_STAR);
         4:       text_buf.push_back(CH_SLASH);
         5:       text_buf.push_back(CH_OPEN);
         default: text_buf.push_back(CH_CLOSE);
      endcase
   endtask

   task automatic gen_number();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
      repeat (n) text_buf.push_back(8'($urandom_range("0", "9")));
   endtask

   task automatic gen_ident();
      if ($urandom_range(0, 3) == 0) begin
         // words on the edge of the keyword
         case ($urandom_range(0, 7))
            0:       push_str("let");
            1:       push_str("le");
            2:       push_str("lets");
            3:       push_str("Let");
            4:       push_str("leT");
            5:       push_str("_let");
            6:       push_str("l");
            default: push_str("lex");
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
               0, 1: text_buf.push_back(8'($urandom_range("a", "z")));
               2:    text_buf.push_back(8'($urandom_range("A", "Z")));
               default: text_buf.push_back(CH_UNDER);
            endcase
         end
         // a digit straight after a word switches run kind
         if ($urandom_range(0, 7) == 0)
            gen_number();
      end
   endtask

   task automatic gen_term(input int depth);
      case ($urandom_range(0, 5))
         0, 1: gen_number();
         2, 3: gen_ident();
         4: begin
            if (depth > 0) begin
               text_buf.push_back(CH_OPEN);
               gen_ws(0);
               gen_expr(depth - 1);
               gen_ws(0);
               text_buf.push_back(CH_CLOSE);
            end else begin
               gen_number();
            end
         end
         default: begin
            text_buf.push_back(CH_MINUS);
            if (depth > 0)
               gen_term(depth - 1);
            else
               gen_number();
         end
      endcase
   endtask

   task automatic gen_expr(input int depth);
      int terms;
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) begin
            gen_ws(0);
            case ($urandom_range(0, 3))
               0:       text_buf.push_back(CH_PLUS);
               1:       text_buf.push_back(CH_MINUS);
               2:       text_buf.push_back(CH_STAR);
               default: text_buf.push_back(CH_SLASH);
            endcase
            gen_ws(0);
         end
         gen_term(depth);
      end
   endtask

   task automatic gen_statement();
      gen_ws(0);
      if ($urandom_range(0, 2) == 0) begin
         push_str("let");
         gen_ws(1);
         gen_ident();
         gen_ws(0);
         text_buf.push_back(CH_EQUALS);
         gen_ws(0);
      end
      gen_expr(2);
      gen_ws(0);
   endtask

   task automatic gen_garbage();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 4))
            0:       text_buf.push_back(8'($urandom_range("0", "9")));
            1:       text_buf.push_back(8'($urandom_range("a", "z")));
            2:       push_symbol();
            3:       push_blank();
            default: text_buf.push_back(8'($urandom_range(1, 255)));
         endcase
      end
   endtask

   // ---------------- driving ----------------

   // called and returns at a falling edge; valid stays up across a burst
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case (sender_mode)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 3);
            default: gap = $urandom_range(2, 12);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) begin
         items_sent++;
         send_byte(text_buf[i]);
      end
      text_buf.delete();
   endtask

   // sender stops until every token due has come out
   task automatic drain_tokens();
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (tokens_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver: random stall patterns, plus long hold-offs on request
   initial begin : receiver
      int stall_left;
      int stall_len;
      int cycle_count;
      int stall_mode;
      stall_left  = 0;
      cycle_count = 0;
      stall_mode  = 0;
      forever begin
         @(negedge clock);
         if (holds_served < hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_served++;
         end else begin
            if (cycle_count % 256 == 0)
               stall_mode = $urandom_range(0, 3);
            cycle_count++;
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               case (stall_mode)
                  0:       stall_len = 0;
                  1:       stall_len = ($urandom_range(0, 3) == 0) ? 1 : 0;
                  2:       stall_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
                  default: stall_len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0;
               endcase
               rsp_ready <= (stall_len == 0);
               stall_left = (stall_len > 0) ? stall_len - 1 : 0;
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d tokens still due", tokens_outstanding);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int random_base;
      int pick;
      int at;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: keyword, run switches, every symbol, high bytes, whitespace,
      // flush at end of text and an empty text
      sender_mode = 1;
      push_str("let A_=12x9+(0)*/-");
      text_buf.push_back(8'h80);
      text_buf.push_back(8'hFF);
      text_buf.push_back(CH_TAB);
      text_buf.push_back(CH_LF);
      text_buf.push_back(CH_CR);
      push_str("e");
      text_buf.push_back(CH_NUL);
      text_buf.push_back(CH_NUL);
      send_text();
      drain_tokens();

      // long receiver hold-off while bytes keep coming, so the queue backs up
      sender_mode = 0;
      hold_requests++;
      repeat (48) push_symbol();
      text_buf.push_back(CH_NUL);
      send_text();
      drain_tokens();

      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         sender_mode = $urandom_range(0, 2);
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4, 5: gen_statement();
            6: gen_garbage();
            7: begin
               gen_statement();
               at = $urandom_range(0, text_buf.size());
               text_buf.insert(at, 8'($urandom_range(1, 255)));
            end
            8: begin
               repeat ($urandom_range(2, 4)) begin
                  gen_statement();
                  text_buf.push_back(CH_LF);
               end
            end
            default: begin
               if ($urandom_range(0, 1) == 0)
                  gen_ws(1);
            end
         endcase
         text_buf.push_back(CH_NUL);
         if ($urandom_range(0, 49) == 0)
            hold_requests++;
         send_text();
         if ($urandom_range(0, 19) == 0)
            drain_tokens();
      end

      drain_tokens();

      $display("lexed %0d bytes into %0d checked tokens, %0d of 12 token kinds seen",
               bytes_lexed, tokens_checked, $countones(kinds_seen));
      $display("covered run switches, keyword near misses, high bytes, hold-offs, back-pressure");
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
design/etl_pkg.sv
design/etl_core.sv
design/etl_fifo.sv
design/expression_token_lexer_unit.sv
design/etl_checker.sv
tb/sv/etl_token_checker.sv
tb/sv/tb_top.sv
